[design/assert_macros.svh]
// Assertion macros used by the RTL of the expert slot cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/eslc_pkg.sv]
// Types and constants of the expert slot cache.
package eslc_pkg;

   localparam int ID_FIELDS = 8;
   localparam int ID_W      = 9;
   localparam int STAMP_W   = 64;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_DUP    = 3'd1,
      ERR_LAYER  = 3'd2,
      ERR_RANGE  = 3'd3,
      ERR_VICTIM = 3'd4,
      ERR_HALT   = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      CSR_ROUTE_COUNT  = 3'd0,
      CSR_EXPERT_TOTAL = 3'd1,
      CSR_SLOTS_IN_USE = 3'd2,
      CSR_FIRST_LAYER  = 3'd3,
      CSR_END_LAYER    = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_APPLY,
      ST_WB
   } state_type;

   typedef struct packed {
      logic [5:0] layer_number;
      logic [8:0] route_id_0;
      logic [8:0] route_id_1;
      logic [8:0] route_id_2;
      logic [8:0] route_id_3;
      logic [8:0] route_id_4;
      logic [8:0] route_id_5;
      logic [8:0] route_id_6;
      logic [8:0] route_id_7;
   } req_type;

   typedef struct packed {
      logic [2:0] route_position;
      logic [3:0] slot_index;
      logic       hit;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    expert;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

endpackage

[design/expert_slot_lru_cache_top.sv]
// Expert slot cache: one layer row per event, scanned slot by slot, written back.
// Busy covers a load state, then per id a check state, a scan of the ns active slots
// and an apply state, then write-back, which range and victim errors reach early.
// Each id's beat comes the cycle after its apply; the receiver cannot stall results.
// Halt, duplicate and layer errors answer in the cycle after start, busy stays low.
// Synchronous reset clears config to defaults, row valid bits, sticky error and control.
`include "assert_macros.svh"

module expert_slot_lru_cache_top #(
   parameter int MAX_SLOTS   = 16,
   parameter int MAX_ROUTES  = 8,
   parameter int MAX_LAYERS  = 64,
   parameter int MAX_EXPERTS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  eslc_pkg::req_type  req_data,
   output logic               rsp_valid,
   output eslc_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_idx,
   input  logic [9:0]         csr_wdata
);

   localparam int SIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int NF  = eslc_pkg::ID_FIELDS;

   typedef struct packed {
      logic [eslc_pkg::STAMP_W-1:0]           clock;
      eslc_pkg::slot_type [MAX_SLOTS-1:0]     slot;
   } row_type;

   // configuration
   logic [3:0] route_count_ff;
   logic [9:0] expert_total_ff;
   logic [4:0] slots_in_use_ff;
   logic [5:0] first_layer_ff;
   logic [6:0] end_layer_ff;

   eslc_pkg::state_type state_ff, state_in;

   row_type                   row_mem [MAX_LAYERS];
   row_type                   rd_ff;
   logic                      rd_vld_ff;
   logic [MAX_LAYERS-1:0]     row_vld_ff;
   row_type                   work_ff;

   logic [eslc_pkg::ID_W-1:0] ids_ff [NF];
   logic [eslc_pkg::ID_W-1:0] req_ids [NF];
   logic [LW-1:0]             layer_ff;
   logic [2:0]                pos_ff;
   logic [SIW-1:0]            sc_ff;
   logic                      hit_ff, emp_ff, lru_ff;
   logic [SIW-1:0]            hit_idx_ff, emp_idx_ff, lru_idx_ff;
   logic [eslc_pkg::STAMP_W-1:0] lru_stamp_ff;
   logic                      sticky_ff, sticky_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   eslc_pkg::rsp_type         rsp_ff, rsp_in;

   logic [3:0]                n_w;
   logic [31:0]               ns_w, limit_w;
   logic                      accept, dup_bad, layer_bad, range_bad, in_event;
   logic                      last_slot, last_id;
   logic [eslc_pkg::ID_W-1:0] cur_id;
   eslc_pkg::slot_type        cur_slot;
   logic [SIW-1:0]            pick_idx;
   logic                      pick_ok;

   assign req_ids[0] = req_data.route_id_0;
   assign req_ids[1] = req_data.route_id_1;
   assign req_ids[2] = req_data.route_id_2;
   assign req_ids[3] = req_data.route_id_3;
   assign req_ids[4] = req_data.route_id_4;
   assign req_ids[5] = req_data.route_id_5;
   assign req_ids[6] = req_data.route_id_6;
   assign req_ids[7] = req_data.route_id_7;

   assign n_w = (route_count_ff == 4'd0) ? 4'd1 :
                ((32'(route_count_ff) > 32'(MAX_ROUTES)) ? 4'(MAX_ROUTES) : route_count_ff);
   assign ns_w = (slots_in_use_ff == 5'd0) ? 32'd1 :
                 ((32'(slots_in_use_ff) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS)
                                                         : 32'(slots_in_use_ff));
   assign limit_w = (32'(expert_total_ff) > 32'(MAX_EXPERTS)) ? 32'(MAX_EXPERTS)
                                                             : 32'(expert_total_ff);

   assign accept = start && (state_ff == eslc_pkg::ST_IDLE);
   assign busy   = (state_ff != eslc_pkg::ST_IDLE);

   always_comb begin
      dup_bad = 1'b0;
      for (int i = 0; i < NF; i++) begin
         for (int j = i + 1; j < NF; j++) begin
            if ((j < int'(n_w)) && (req_ids[i] == req_ids[j])) begin
               dup_bad = 1'b1;
            end
         end
      end
   end

   assign layer_bad = (req_data.layer_number < first_layer_ff) ||
                      ({1'b0, req_data.layer_number} >= end_layer_ff) ||
                      (32'(req_data.layer_number) >= 32'(MAX_LAYERS));

   assign cur_id    = ids_ff[pos_ff];
   assign cur_slot  = work_ff.slot[sc_ff];
   assign range_bad = (32'(cur_id) >= limit_w);
   assign last_slot = ((32'(sc_ff) + 32'd1) == ns_w);
   assign last_id   = (({1'b0, pos_ff} + 4'd1) == n_w);

   always_comb begin
      in_event = 1'b0;
      for (int k = 0; k < NF; k++) begin
         if ((k < int'(n_w)) && (ids_ff[k] == cur_slot.expert)) begin
            in_event = 1'b1;
         end
      end
   end

   // hit first, then first empty slot, then least recently used unpinned slot
   always_comb begin
      pick_ok  = 1'b1;
      pick_idx = lru_idx_ff;
      priority if (hit_ff) begin
         pick_idx = hit_idx_ff;
      end else if (emp_ff) begin
         pick_idx = emp_idx_ff;
      end else if (lru_ff) begin
         pick_idx = lru_idx_ff;
      end else begin
         pick_ok = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eslc_pkg::ST_IDLE: begin
            if (accept && !sticky_ff && !dup_bad && !layer_bad) begin
               state_in = eslc_pkg::ST_LOAD;
            end
         end
         eslc_pkg::ST_LOAD:  state_in = eslc_pkg::ST_CHECK;
         eslc_pkg::ST_CHECK: state_in = range_bad ? eslc_pkg::ST_WB : eslc_pkg::ST_SCAN;
         eslc_pkg::ST_SCAN:  state_in = last_slot ? eslc_pkg::ST_APPLY : eslc_pkg::ST_SCAN;
         eslc_pkg::ST_APPLY: begin
            state_in = (!pick_ok || last_id) ? eslc_pkg::ST_WB : eslc_pkg::ST_CHECK;
         end
         eslc_pkg::ST_WB:    state_in = eslc_pkg::ST_IDLE;
         default:            state_in = eslc_pkg::ST_IDLE;
      endcase
   end

   // result beat and sticky error
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      sticky_in    = sticky_ff;
      unique case (state_ff)
         eslc_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.last = 1'b1;
               priority if (sticky_ff) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.error_code = eslc_pkg::ERR_HALT;
               end else if (dup_bad) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.error_code = eslc_pkg::ERR_DUP;
                  sticky_in         = 1'b1;
               end else if (layer_bad) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.error_code = eslc_pkg::ERR_LAYER;
                  sticky_in         = 1'b1;
               end else begin
                  rsp_in.last = 1'b0;
               end
            end
         end
         eslc_pkg::ST_CHECK: begin
            if (range_bad) begin
               rsp_valid_in          = 1'b1;
               rsp_in.route_position = pos_ff;
               rsp_in.error_code     = eslc_pkg::ERR_RANGE;
               rsp_in.last           = 1'b1;
               sticky_in             = 1'b1;
            end
         end
         eslc_pkg::ST_APPLY: begin
            rsp_valid_in          = 1'b1;
            rsp_in.route_position = pos_ff;
            if (pick_ok) begin
               rsp_in.slot_index = 4'(pick_idx);
               rsp_in.hit        = hit_ff;
               rsp_in.last       = last_id;
            end else begin
               rsp_in.error_code = eslc_pkg::ERR_VICTIM;
               rsp_in.last       = 1'b1;
               sticky_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= eslc_pkg::ST_IDLE;
         sticky_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         row_vld_ff      <= '0;
         route_count_ff  <= 4'd8;
         expert_total_ff <= 10'd256;
         slots_in_use_ff <= 5'd16;
         first_layer_ff  <= 6'd0;
         end_layer_ff    <= 7'd64;
      end else begin
         state_ff     <= state_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == eslc_pkg::ST_WB) begin
            row_vld_ff[layer_ff] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_idx)
               eslc_pkg::CSR_ROUTE_COUNT:  route_count_ff  <= csr_wdata[3:0];
               eslc_pkg::CSR_EXPERT_TOTAL: expert_total_ff <= csr_wdata;
               eslc_pkg::CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[4:0];
               eslc_pkg::CSR_FIRST_LAYER:  first_layer_ff  <= csr_wdata[5:0];
               eslc_pkg::CSR_END_LAYER:    end_layer_ff    <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // row memory: one read port, one write port, registered read
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= row_mem[LW'(req_data.layer_number)];
         rd_vld_ff <= row_vld_ff[LW'(req_data.layer_number)];
      end
      if (state_ff == eslc_pkg::ST_WB) begin
         row_mem[layer_ff] <= work_ff;
      end
   end

   // working row and scan trackers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      unique case (state_ff)
         eslc_pkg::ST_IDLE: begin
            if (accept) begin
               layer_ff <= LW'(req_data.layer_number);
               for (int k = 0; k < NF; k++) begin
                  ids_ff[k] <= req_ids[k];
               end
            end
         end
         eslc_pkg::ST_LOAD: begin
            work_ff <= rd_vld_ff ? rd_ff : '0;
            pos_ff  <= 3'd0;
         end
         eslc_pkg::ST_CHECK: begin
            sc_ff  <= '0;
            hit_ff <= 1'b0;
            emp_ff <= 1'b0;
            lru_ff <= 1'b0;
         end
         eslc_pkg::ST_SCAN: begin
            sc_ff <= sc_ff + SIW'(1);
            if (!hit_ff && cur_slot.valid && (cur_slot.expert == cur_id)) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= sc_ff;
            end
            if (!emp_ff && !cur_slot.valid) begin
               emp_ff     <= 1'b1;
               emp_idx_ff <= sc_ff;
            end
            if (cur_slot.valid && !in_event &&
                (!lru_ff || (cur_slot.stamp < lru_stamp_ff))) begin
               lru_ff       <= 1'b1;
               lru_idx_ff   <= sc_ff;
               lru_stamp_ff <= cur_slot.stamp;
            end
         end
         eslc_pkg::ST_APPLY: begin
            pos_ff <= pos_ff + 3'd1;
            if (pick_ok) begin
               work_ff.clock                <= work_ff.clock + 64'd1;
               work_ff.slot[pick_idx].valid  <= 1'b1;
               work_ff.slot[pick_idx].expert <= cur_id;
               work_ff.slot[pick_idx].stamp  <= work_ff.clock + 64'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEXT(a_halt_reply, clock, reset, accept && sticky_ff,
      rsp_valid && (rsp_data.error_code == eslc_pkg::ERR_HALT))
   `ASSERT_IMPLY(a_error_is_last, clock, reset,
      rsp_valid && (rsp_data.error_code != eslc_pkg::ERR_NONE), rsp_data.last)
   `ASSERT_NEXT(a_scan_exit, clock, reset, state_ff == eslc_pkg::ST_SCAN,
      (state_ff == eslc_pkg::ST_SCAN) || (state_ff == eslc_pkg::ST_APPLY))
   `ASSERT_IMPLY(a_final_writes_back, clock, reset,
      rsp_valid && rsp_data.last && (rsp_data.error_code == eslc_pkg::ERR_NONE),
      state_ff == eslc_pkg::ST_WB)

endmodule

[dv/tb_expert_slot_lru_cache_top.sv]
// Self-checking testbench for the expert slot LRU cache top level.
`timescale 1ns / 1ps

module tb_expert_slot_lru_cache_top;

   localparam int ROWS       = 64;
   localparam int ROW_SLOTS  = 16;
   localparam int SETTLE     = 200;
   localparam int STALL_MAX  = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   eslc_pkg::req_type req_data = '0;
   logic    rsp_valid;
   eslc_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0] csr_idx = '0;
   logic [9:0] csr_wdata = '0;

   expert_slot_lru_cache_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow configuration
   int unsigned cfg_routes, cfg_experts, cfg_slots, cfg_first, cfg_end;

   // shadow slot tables
   bit                row_valid [ROWS][ROW_SLOTS];
   logic [8:0]        row_expert[ROWS][ROW_SLOTS];
   longint unsigned   row_stamp [ROWS][ROW_SLOTS];
   longint unsigned   use_clock [ROWS];
   bit                halted;

   eslc_pkg::rsp_type pending_slots[$];
   int      fail_count  = 0;
   int      events_sent = 0;
   int      results_seen = 0;
   int      hits_seen   = 0;
   int      idle_pct    = 0;
   int      stall_cycles = 0;

   function automatic eslc_pkg::rsp_type make_rsp(int pos, int slot, bit h,
                                                  eslc_pkg::err_type e, bit lst);
      eslc_pkg::rsp_type x;
      x.route_position = pos[2:0];
      x.slot_index     = slot[3:0];
      x.hit            = h;
      x.error_code     = e;
      x.last           = lst;
      return x;
   endfunction

   // Work out the results of one event; return 1 if it completes without error.
   // With apply set, queue the results and update the shadow tables.
   function automatic bit lookup_event(input eslc_pkg::req_type r, input bit apply);
      logic [8:0]      ids[8];
      int              n, ns, lim, lay, found, victim;
      bit              rv[ROW_SLOTS];
      logic [8:0]      re[ROW_SLOTS];
      longint unsigned rs[ROW_SLOTS];
      longint unsigned clk;
      bit              ok, stop, pinned;
      eslc_pkg::rsp_type outq[$];
      ids = '{r.route_id_0, r.route_id_1, r.route_id_2, r.route_id_3,
              r.route_id_4, r.route_id_5, r.route_id_6, r.route_id_7};
      ok   = 1'b1;
      stop = 1'b0;
      lay  = r.layer_number;
      n    = (cfg_routes == 0) ? 1 : (cfg_routes > 8 ? 8 : cfg_routes);
      ns   = (cfg_slots == 0) ? 1 : (cfg_slots > ROW_SLOTS ? ROW_SLOTS : cfg_slots);
      lim  = (cfg_experts > 512) ? 512 : cfg_experts;
      for (int s = 0; s < ROW_SLOTS; s++) begin
         rv[s] = row_valid[lay][s];
         re[s] = row_expert[lay][s];
         rs[s] = row_stamp[lay][s];
      end
      clk = use_clock[lay];
      if (halted) begin
         outq.insert(outq.size(), make_rsp(0, 0, 0, eslc_pkg::ERR_HALT, 1));
         ok = 0;
         stop = 1;
      end
      for (int i = 0; i < n && !stop; i++)
         for (int j = i + 1; j < n && !stop; j++)
            if (ids[i] == ids[j]) begin
               outq.insert(outq.size(), make_rsp(0, 0, 0, eslc_pkg::ERR_DUP, 1));
               ok = 0;
               stop = 1;
            end
      if (!stop && (lay < cfg_first || lay >= cfg_end)) begin
         outq.insert(outq.size(), make_rsp(0, 0, 0, eslc_pkg::ERR_LAYER, 1));
         ok = 0;
         stop = 1;
      end
      for (int i = 0; i < n && !stop; i++) begin
         found  = -1;
         victim = -1;
         if (ids[i] >= lim) begin
            outq.insert(outq.size(), make_rsp(i, 0, 0, eslc_pkg::ERR_RANGE, 1));
            ok = 0;
            stop = 1;
            break;
         end
         for (int s = 0; s < ns; s++)
            if (rv[s] && re[s] == ids[i]) begin
               found = s;
               break;
            end
         if (found >= 0) begin
            clk++;
            rs[found] = clk;
            outq.insert(outq.size(), make_rsp(i, found, 1, eslc_pkg::ERR_NONE, i + 1 == n));
            continue;
         end
         for (int s = 0; s < ns; s++) begin
            if (!rv[s]) begin
               victim = s;
               break;
            end
            pinned = 0;
            for (int k = 0; k < n; k++)
               if (ids[k] == re[s]) pinned = 1;
            if (!pinned && (victim < 0 || rs[s] < rs[victim])) victim = s;
         end
         if (victim < 0) begin
            outq.insert(outq.size(), make_rsp(i, 0, 0, eslc_pkg::ERR_VICTIM, 1));
            ok = 0;
            stop = 1;
            break;
         end
         clk++;
         rv[victim] = 1;
         re[victim] = ids[i];
         rs[victim] = clk;
         outq.insert(outq.size(), make_rsp(i, victim, 0, eslc_pkg::ERR_NONE, i + 1 == n));
      end
      if (apply) begin
         foreach (outq[k]) pending_slots.insert(pending_slots.size(), outq[k]);
         if (!ok) halted = 1;
         if (lay >= cfg_first && lay < cfg_end) begin
            for (int s = 0; s < ROW_SLOTS; s++) begin
               row_valid[lay][s]  = rv[s];
               row_expert[lay][s] = re[s];
               row_stamp[lay][s]  = rs[s];
            end
            use_clock[lay] = clk;
         end
      end
      return ok;
   endfunction

   function automatic eslc_pkg::req_type build_event(int lay, logic [8:0] ids[8]);
      return {lay[5:0], ids[0], ids[1], ids[2], ids[3], ids[4], ids[5], ids[6], ids[7]};
   endfunction

   // Drop start and let it be sampled low, so the next raise is a separate step.
   task automatic hold_start();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_event(eslc_pkg::req_type r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      void'(lookup_event(r, 1'b1));
      events_sent++;
   endtask

   task automatic wait_drained();
      hold_start();
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(eslc_pkg::csr_idx_type idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val[9:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         eslc_pkg::CSR_ROUTE_COUNT:  cfg_routes  = val & 'hF;
         eslc_pkg::CSR_EXPERT_TOTAL: cfg_experts = val & 'h3FF;
         eslc_pkg::CSR_SLOTS_IN_USE: cfg_slots   = val & 'h1F;
         eslc_pkg::CSR_FIRST_LAYER:  cfg_first   = val & 'h3F;
         eslc_pkg::CSR_END_LAYER:    cfg_end     = val & 'h7F;
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned rc, int unsigned et, int unsigned ns,
                            int unsigned fl, int unsigned el);
      wait_drained();
      write_csr(eslc_pkg::CSR_ROUTE_COUNT, rc);
      write_csr(eslc_pkg::CSR_EXPERT_TOTAL, et);
      write_csr(eslc_pkg::CSR_SLOTS_IN_USE, ns);
      write_csr(eslc_pkg::CSR_FIRST_LAYER, fl);
      write_csr(eslc_pkg::CSR_END_LAYER, el);
   endtask

   // Ids base..base+7 on one layer.
   function automatic eslc_pkg::req_type run_of_ids(int lay, int base);
      logic [8:0] ids[8];
      for (int i = 0; i < 8; i++) ids[i] = 9'(base + i);
      return build_event(lay, ids);
   endfunction

   task automatic test_directed();
      logic [8:0] ids[8];
      // fill both layer extremes, then revisit for hits
      send_event(run_of_ids(0, 0));
      send_event(run_of_ids(63, 248));
      send_event(run_of_ids(0, 0));
      send_event(run_of_ids(63, 248));
      send_event(run_of_ids(0, 4));
      configure(8, 512, 16, 0, 64);
      send_event(run_of_ids(63, 504));
      send_event(run_of_ids(63, 504));
      // pinning: LRU slot holds an id of the same event, so the other slot goes
      configure(2, 512, 2, 0, 64);
      for (int i = 0; i < 8; i++) ids[i] = 9'(511 - i);
      ids[0] = 100; ids[1] = 101;
      send_event(build_event(5, ids));
      ids[0] = 102; ids[1] = 100;
      send_event(build_event(5, ids));
      ids[0] = 100; ids[1] = 102;
      send_event(build_event(5, ids));
      // slots outside the active count keep their contents
      configure(1, 512, 1, 0, 64);
      ids[0] = 300;
      send_event(build_event(0, ids));
      configure(1, 512, 16, 0, 64);
      ids[0] = 5;
      send_event(build_event(0, ids));
      ids[0] = 300;
      send_event(build_event(0, ids));
   endtask

   task automatic test_random_phase(int count, int unsigned rc, int unsigned et,
                                    int unsigned ns, int unsigned fl, int unsigned el,
                                    int pct, bit pause);
      logic [8:0] ids[8];
      eslc_pkg::req_type r;
      int         n, hot, tries;
      bit         dup;
      configure(rc, et, ns, fl, el);
      idle_pct = pct;
      n   = (rc > 8) ? 8 : rc;
      hot = 3 * ns;
      if (hot < n + 2) hot = n + 2;
      if (hot > et) hot = et;
      for (int k = 0; k < count; k++) begin
         if (pause && k == count / 2) begin
            hold_start();
            while (pending_slots.size() != 0) @(posedge clock);
         end
         tries = 0;
         do begin
            for (int i = 0; i < 8; i++) ids[i] = 9'($urandom_range(511));
            for (int i = 0; i < n; i++)
               do begin
                  ids[i] = 9'(($urandom_range(99) < 60) ? $urandom_range(hot - 1)
                                                        : $urandom_range(et - 1));
                  dup = 0;
                  for (int j = 0; j < i; j++) if (ids[j] == ids[i]) dup = 1;
               end while (dup);
            r = build_event($urandom_range(fl, el - 1), ids);
            tries++;
         end while (!lookup_event(r, 1'b0) && tries < 20);
         if (tries < 20 || lookup_event(r, 1'b0)) send_event(r);
      end
   endtask

   // One error kind goes first and latches the halt; the rest then report halted.
   task automatic test_errors();
      logic [8:0] ids[8];
      int         kind;
      configure(3, 100, 2, 10, 20);
      kind = $urandom_range(3);
      for (int i = 0; i < 8; i++) ids[i] = 9'(40 + i);
      case (kind)
         0: ids[1] = ids[0];
         1: ;
         2: ids[1] = 250;
         default: ;
      endcase
      send_event(build_event(kind == 1 ? 3 : 12, ids));
      ids[1] = ids[0];
      send_event(build_event(12, ids));
      send_event(build_event(25, ids));
      for (int i = 0; i < 8; i++) ids[i] = 9'(i);
      send_event(build_event(12, ids));
   endtask

   always @(posedge clock) begin
      eslc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_data.hit) hits_seen++;
         if (pending_slots.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = pending_slots.pop_front();
            if (rsp_data.route_position !== want.route_position ||
                rsp_data.slot_index !== want.slot_index || rsp_data.hit !== want.hit ||
                rsp_data.error_code !== want.error_code || rsp_data.last !== want.last) begin
               $display("%0t: mismatch, expected %p actual %p", $realtime, want, rsp_data);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_MAX) begin
         $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                  pending_slots.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      cfg_routes = 8; cfg_experts = 256; cfg_slots = 16; cfg_first = 0; cfg_end = 64;
      halted = 0;
      foreach (use_clock[l]) begin
         use_clock[l] = 0;
         for (int s = 0; s < ROW_SLOTS; s++) begin
            row_valid[l][s] = 0; row_expert[l][s] = 0; row_stamp[l][s] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(75, 8, 512, 16, 0, 64, 32, 0);
      test_random_phase(75, 1, 2, 1, 63, 64, 32, 0);
      test_random_phase(75, 3, 40, 5, 20, 24, 48, 1);
      test_random_phase(75, 8, 300, 12, 0, 1, 48, 0);
      test_random_phase(75, 2, 16, 3, 30, 40, 0, 0);
      test_random_phase(75, 6, 512, 16, 0, 64, 0, 0);
      test_errors();
      hold_start();
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d routing events: directed fills, pinning and partial rows, then",
               events_sent);
      $display("six random register settings and a latched error; %0d results, %0d hits.",
               results_seen, hits_seen);
      if (fail_count == 0 && pending_slots.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
